// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define QPV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QPV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QPV_ASSERT(lbl, clk, rst, prop, msg)
`define QPV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: src/qpv_pkg.sv
package qpv_pkg;

   localparam int AXES_DEF = 2;

   localparam int DATA_W   = 32;
   localparam int DT_W     = 16;
   localparam int DIV_BITS = 2;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic        axis_select;
      logic        pin_a;
      logic        pin_b;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] acceleration;
      logic               rate_updated;
   } rsp_type;

   // quadrature step from {old_b, old_a, new_b, new_a}
   function automatic logic [DATA_W-1:0] dir_step(input logic [3:0] idx);
      logic [DATA_W-1:0] step;
      unique case (idx)
         4'd2, 4'd4, 4'd11, 4'd13: step = DATA_W'(1);
         4'd1, 4'd7, 4'd8, 4'd14:  step = '1;
         default:                  step = '0;
      endcase
      return step;
   endfunction

endpackage

// File: src/qpv_div.sv
`include "assert_macros.svh"

module qpv_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [qpv_pkg::DATA_W-1:0]      dividend,
   input  logic [qpv_pkg::DT_W-2:0]        divisor,
   output logic                            done,
   output logic [qpv_pkg::DATA_W-1:0]      quotient
);

   localparam int DW    = qpv_pkg::DATA_W;
   localparam int RW    = qpv_pkg::DT_W - 1;
   localparam int STEPS = qpv_pkg::DATA_W / qpv_pkg::DIV_BITS;
   localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [RW-1:0] rem_ff;
   logic [DW-1:0] quo_ff;
   logic [RW-1:0] div_ff;

   logic [RW-1:0] rem_in;
   logic [DW-1:0] quo_in;

   always_comb begin
      logic [RW:0]   r;
      logic [DW-1:0] q;
      r = {1'b0, rem_ff};
      q = quo_ff;
      for (int i = 0; i < qpv_pkg::DIV_BITS; i++) begin
         r = {r[RW-1:0], q[DW-1]};
         q = {q[DW-2:0], 1'b0};
         if (r >= {1'b0, div_ff}) begin
            r    = r - {1'b0, div_ff};
            q[0] = 1'b1;
         end
      end
      rem_in = r[RW-1:0];
      quo_in = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `QPV_ASSERT(a_start_idle, clock, reset, start |-> !busy_ff, "divider restarted while busy")
   `QPV_ASSERT(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff), "done without run")
   `QPV_ASSERT(a_rem_bound, clock, reset, busy_ff |-> (rem_ff < div_ff), "remainder out of range")

endmodule

// File: src/quadrature_position_velocity_top.sv
// Two-axis quadrature position and velocity block.
// req channel (req_valid/req_ready/req_data): one beat is either a pin sample
// (A/B levels of one axis) or a rate update (axis and millisecond time).
// rsp channel (rsp_valid/rsp_ready/rsp_data): exactly one beat per request,
// carrying position, velocity, acceleration and a rate_updated flag.
// Requests are handled one at a time; req_ready is high only when idle.
// Pin sample: the result goes from S_EXEC through S_EMIT into the rsp output
// register. Rate update with a positive time step: the result is set by two
// passes through the shared serial divider (2 quotient bits per cycle), for
// velocity and then acceleration; otherwise it is emitted without a division.
// A finished result sits in the rsp output register; while it waits for
// rsp_ready the block goes back to idle and takes the next request, which
// then holds in its final state until the register frees up.
// Synchronous reset clears all axis counts, pin states, timestamps and rates
// to zero and drops rsp_valid. Items for an axis at or above AXES return all
// zero fields.
`include "assert_macros.svh"

module quadrature_position_velocity_top #(
   parameter int AXES = qpv_pkg::AXES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qpv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qpv_pkg::rsp_type rsp_data
);

   localparam int DW  = qpv_pkg::DATA_W;
   localparam int TW  = qpv_pkg::DT_W;
   localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_PREP, S_DIV_V, S_ADIFF, S_DIV_A, S_EMIT
   } state_type;

   state_type        state_ff;
   qpv_pkg::req_type item_ff;
   qpv_pkg::rsp_type res_ff;
   qpv_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;

   logic [DW-1:0] count_ff [AXES];
   logic [DW-1:0] cau_ff   [AXES];
   logic [1:0]    pin_ff   [AXES];
   logic [DW-1:0] tau_ff   [AXES];
   logic [DW-1:0] speed_ff [AXES];
   logic [DW-1:0] accel_ff [AXES];

   logic [DW-1:0] change_ff;
   logic [TW-1:0] dt_ff;
   logic [DW-1:0] abs_sp_ff;
   logic [DW:0]   diff_ff;
   logic          vneg_ff;
   logic          aneg_ff;

   logic [AXW-1:0] ax;
   logic           in_range;
   logic [DW-1:0]  count_in;
   logic           dt_pos;
   logic           div_start;
   logic [DW-1:0]  div_dividend;
   logic           div_done;
   logic [DW-1:0]  div_q;
   logic           out_free;

   assign ax       = AXW'(item_ff.axis_select);
   assign in_range = (int'(item_ff.axis_select) < AXES);
   assign count_in = count_ff[ax]
                   + qpv_pkg::dir_step({pin_ff[ax], item_ff.pin_b, item_ff.pin_a});
   assign dt_pos   = !dt_ff[TW-1] && (dt_ff != '0);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      if (state_ff == S_PREP && dt_pos) begin
         div_start    = 1'b1;
         div_dividend = change_ff[DW-1] ? (~change_ff + DW'(1)) : change_ff;
      end else if (state_ff == S_ADIFF) begin
         div_start    = 1'b1;
         div_dividend = diff_ff[DW] ? (~diff_ff[DW-1:0] + DW'(1)) : diff_ff[DW-1:0];
      end
   end

   qpv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (dt_ff[TW-2:0]),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            count_ff[i] <= '0;
            cau_ff[i]   <= '0;
            pin_ff[i]   <= '0;
            tau_ff[i]   <= '0;
            speed_ff[i] <= '0;
            accel_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_data;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (!in_range) begin
                  res_ff   <= '0;
                  state_ff <= S_EMIT;
               end else if (item_ff.opcode == qpv_pkg::OP_SAMPLE) begin
                  count_ff[ax]        <= count_in;
                  pin_ff[ax]          <= {item_ff.pin_b, item_ff.pin_a};
                  res_ff.position     <= count_in;
                  res_ff.velocity     <= speed_ff[ax];
                  res_ff.acceleration <= accel_ff[ax];
                  res_ff.rate_updated <= 1'b0;
                  state_ff            <= S_EMIT;
               end else begin
                  change_ff  <= count_ff[ax] - cau_ff[ax];
                  dt_ff      <= item_ff.now_ms[TW-1:0] - tau_ff[ax][TW-1:0];
                  abs_sp_ff  <= speed_ff[ax][DW-1] ? (~speed_ff[ax] + DW'(1)) : speed_ff[ax];
                  cau_ff[ax] <= count_ff[ax];
                  state_ff   <= S_PREP;
               end
            end
            S_PREP: begin
               if (dt_pos) begin
                  vneg_ff  <= change_ff[DW-1];
                  state_ff <= S_DIV_V;
               end else begin
                  res_ff.position     <= count_ff[ax];
                  res_ff.velocity     <= speed_ff[ax];
                  res_ff.acceleration <= accel_ff[ax];
                  res_ff.rate_updated <= 1'b0;
                  state_ff            <= S_EMIT;
               end
            end
            S_DIV_V: begin
               if (div_done) begin
                  speed_ff[ax] <= vneg_ff ? (~div_q + DW'(1)) : div_q;
                  diff_ff      <= {1'b0, div_q} - {1'b0, abs_sp_ff};
                  state_ff     <= S_ADIFF;
               end
            end
            S_ADIFF: begin
               aneg_ff  <= diff_ff[DW];
               state_ff <= S_DIV_A;
            end
            S_DIV_A: begin
               if (div_done) begin
                  accel_ff[ax]        <= aneg_ff ? (~div_q + DW'(1)) : div_q;
                  tau_ff[ax]          <= item_ff.now_ms;
                  res_ff.position     <= count_ff[ax];
                  res_ff.velocity     <= speed_ff[ax];
                  res_ff.acceleration <= aneg_ff ? (~div_q + DW'(1)) : div_q;
                  res_ff.rate_updated <= 1'b1;
                  state_ff            <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `QPV_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "accepted beat while busy")
   `QPV_ASSERT(a_div_done_state, clock, reset, div_done |-> (state_ff == S_DIV_V || state_ff == S_DIV_A), "divider result unexpected")
   `QPV_ASSERT(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT), "result loaded outside emit")

endmodule

// File: sim/tb_top.sv
module tb_top;

   localparam int ITEM_TARGET = 1550;
   localparam int HOLD_CYCLES = 400;

   // position of each pin state along the quadrature cycle, and its inverse
   localparam int         GRAY_POS [4] = '{0, 3, 1, 2};
   localparam logic [1:0] POS_PINS [4] = '{2'd0, 2'd2, 2'd3, 2'd1};
   // covers every old/new pin pair once, starting from the reset state
   localparam logic [1:0] PIN_WALK [16] = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
                                            2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   qpv_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   qpv_pkg::rsp_type rsp_data;

   quadrature_position_velocity_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // encoder state as predicted
   logic [31:0] enc_count      [qpv_pkg::AXES_DEF] = '{default: '0};
   logic [31:0] count_at_stamp [qpv_pkg::AXES_DEF] = '{default: '0};
   logic [1:0]  pin_level      [qpv_pkg::AXES_DEF] = '{default: '0};
   logic [31:0] stamp_ms       [qpv_pkg::AXES_DEF] = '{default: '0};
   logic [31:0] speed_now      [qpv_pkg::AXES_DEF] = '{default: '0};
   logic [31:0] prev_speed     [qpv_pkg::AXES_DEF] = '{default: '0};
   logic [31:0] accel_now      [qpv_pkg::AXES_DEF] = '{default: '0};

   qpv_pkg::rsp_type pending_readings [$];
   int               requests_sent = 0;
   int               mismatches    = 0;
   int               burst_left    = 0;
   bit               hold_off_req  = 1'b0;

   function automatic qpv_pkg::rsp_type predict_encoder_reading(qpv_pkg::req_type beat);
      qpv_pkg::rsp_type res;
      int unsigned      ax;
      logic [1:0]       pins;
      logic [15:0]      span;
      int               quarter;
      longint           change, dt, vel, prev, acc;
      res = '0;
      ax  = beat.axis_select;
      if (ax >= qpv_pkg::AXES_DEF) return res;
      if (beat.opcode == qpv_pkg::OP_SAMPLE) begin
         pins    = {beat.pin_b, beat.pin_a};
         quarter = (GRAY_POS[pins] - GRAY_POS[pin_level[ax]]) & 3;
         if (quarter == 1) enc_count[ax] = enc_count[ax] + 32'd1;
         else if (quarter == 3) enc_count[ax] = enc_count[ax] - 32'd1;
         pin_level[ax] = pins;
      end else begin
         change = longint'($signed(enc_count[ax] - count_at_stamp[ax]));
         span   = 16'(beat.now_ms - stamp_ms[ax]);
         dt     = longint'($signed(span));
         if (dt > 0) begin
            vel  = change / dt;
            prev = longint'($signed(prev_speed[ax]));
            acc  = ((vel < 0 ? -vel : vel) - (prev < 0 ? -prev : prev)) / dt;
            speed_now[ax]    = vel[31:0];
            accel_now[ax]    = acc[31:0];
            prev_speed[ax]   = vel[31:0];
            stamp_ms[ax]     = beat.now_ms;
            res.rate_updated = 1'b1;
         end
         count_at_stamp[ax] = enc_count[ax];
      end
      res.position     = enc_count[ax];
      res.velocity     = speed_now[ax];
      res.acceleration = accel_now[ax];
      return res;
   endfunction

   function automatic qpv_pkg::req_type sample_beat(logic ax, logic [1:0] pins);
      qpv_pkg::req_type beat;
      beat.opcode      = qpv_pkg::OP_SAMPLE;
      beat.axis_select = ax;
      beat.pin_a       = pins[0];
      beat.pin_b       = pins[1];
      beat.now_ms      = $urandom();
      return beat;
   endfunction

   function automatic qpv_pkg::req_type update_beat(logic ax, logic [31:0] now);
      qpv_pkg::req_type beat;
      beat.opcode      = qpv_pkg::OP_UPDATE;
      beat.axis_select = ax;
      beat.pin_a       = 1'($urandom_range(0, 1));
      beat.pin_b       = 1'($urandom_range(0, 1));
      beat.now_ms      = now;
      return beat;
   endfunction

   // call at a rising edge; returns once the beat is taken and any idle gap is over
   task automatic send_beat(qpv_pkg::req_type beat);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      pending_readings.push_back(predict_encoder_reading(beat));
      requests_sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 10);
      end else begin
         burst_left--;
      end
   endtask

   task automatic test_pin_transitions();
      foreach (PIN_WALK[i]) send_beat(sample_beat(1'b0, PIN_WALK[i]));
      send_beat(sample_beat(1'b1, 2'd2));
      send_beat(sample_beat(1'b1, 2'd3));
      send_beat(sample_beat(1'b1, 2'd1));
   endtask

   task automatic test_update_timing();
      send_beat(update_beat(1'b0, 32'd0));
      send_beat(update_beat(1'b0, 32'd5));
      send_beat(update_beat(1'b0, 32'd5 + 32'h8000));
      send_beat(update_beat(1'b0, 32'd5 + 32'h7FFF));
      send_beat(update_beat(1'b1, 32'hFFFF_FFFF));
      send_beat(update_beat(1'b1, 32'h0001_0000));
   endtask

   // receiver holds off while the sender keeps pushing
   task automatic test_backpressure();
      hold_off_req = 1'b1;
      for (int i = 0; i < 40; i++) begin
         if (i % 8 == 7)
            send_beat(update_beat(1'(i % 2), stamp_ms[i % 2] + 32'd2));
         else
            send_beat(sample_beat(1'(i % 2), POS_PINS[(GRAY_POS[pin_level[i % 2]] + 1) & 3]));
      end
   endtask

   task automatic test_random_traffic();
      int unsigned ax, steps, pick, pos;
      int          dir;
      logic [1:0]  pins;
      logic [31:0] now;
      while (requests_sent < ITEM_TARGET) begin
         ax    = $urandom_range(0, qpv_pkg::AXES_DEF - 1);
         dir   = $urandom_range(0, 1) ? 1 : -1;
         steps = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 150) : $urandom_range(0, 6);
         repeat (steps) begin
            if ($urandom_range(0, 24) == 0) begin
               pins = 2'($urandom_range(0, 3));
            end else begin
               pos  = (GRAY_POS[pin_level[ax]] + dir) & 3;
               pins = POS_PINS[pos];
            end
            send_beat(sample_beat(1'(ax), pins));
         end
         pick = $urandom_range(0, 15);
         case (pick)
            0: begin
               now = stamp_ms[ax];
            end
            1: begin
               now = stamp_ms[ax] + $urandom_range(32768, 65535);
            end
            2: begin
               now = $urandom();
            end
            3: begin
               now = stamp_ms[ax] + $urandom_range(1, 32767);
            end
            default: begin
               now = stamp_ms[ax] + $urandom_range(1, 6);
            end
         endcase
         send_beat(update_beat(1'(ax), now));
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_pin_transitions();
      test_update_timing();
      test_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // receiver: stall pattern re-picked at random from four modes, plus one long hold-off
   initial begin : receiver
      int unsigned mode, tick;
      rsp_ready = 1'b0;
      mode      = 0;
      tick      = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (tick % 50 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_ready <= (tick % 4 == 0);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 7) != 0);
            end
         endcase
         tick++;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : reading_check
      qpv_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $error("result beat with nothing pending");
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_data.position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_data.position);
               mismatches++;
            end
            if (rsp_data.velocity !== want.velocity) begin
               $error("velocity: expected %0d, got %0d", want.velocity, rsp_data.velocity);
               mismatches++;
            end
            if (rsp_data.acceleration !== want.acceleration) begin
               $error("acceleration: expected %0d, got %0d",
                      want.acceleration, rsp_data.acceleration);
               mismatches++;
            end
            if (rsp_data.rate_updated !== want.rate_updated) begin
               $error("rate_updated: expected %0b, got %0b",
                      want.rate_updated, rsp_data.rate_updated);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
